### hw/rtl/svt_pkg.sv
// Shared constants, codes and the table entry type for the satellite view table.
`default_nettype none

package svt_pkg;

	// Table depths
	localparam int VIEW_DEPTH = 32;
	localparam int USE_DEPTH  = 16;

	// Index and fill widths derived from the depths
	localparam int VIEW_IW = (VIEW_DEPTH > 1) ? $clog2(VIEW_DEPTH) : 1;
	localparam int USE_IW  = (USE_DEPTH > 1) ? $clog2(USE_DEPTH) : 1;
	localparam int VIEW_FW = $clog2(VIEW_DEPTH + 1);
	localparam int USE_FW  = $clog2(USE_DEPTH + 1);
	localparam int CNT_W   = (VIEW_FW > USE_FW) ? VIEW_FW : USE_FW;

	// Field widths
	localparam int MODE_W = 3;
	localparam int SYS_W  = 3;
	localparam int NUM_W  = 8;
	localparam int VOS_W  = 6;
	localparam int UOS_W  = 5;
	localparam int VT_W   = 6;
	localparam int UT_W   = 5;

	// Stream widths
	localparam int S_TDATA_W = 16;
	localparam int S_TUSER_W = MODE_W;
	localparam int M_TDATA_W = 24;

	// Operation codes
	localparam logic [MODE_W-1:0] MODE_PURGE     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ADD_VIEW  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ADD_USE   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_CLR_USE   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CLR_ALL   = 3'd4;

	// System code that acts as a wildcard in a used-set match
	localparam logic [SYS_W-1:0] SYS_UNKNOWN = 3'd4;

	typedef struct packed {
		logic [SYS_W-1:0] sys;
		logic [NUM_W-1:0] num;
		logic             mark;
	} entry_t;

endpackage

`default_nettype wire

### hw/rtl/svt_cell.sv
// One storage cell of a table chain: load a broadcast entry or take the neighbour's.
`default_nettype none

module svt_cell (
	input  logic            clk,
	input  logic            shift,
	input  logic            load,
	input  svt_pkg::entry_t nbr,
	input  svt_pkg::entry_t ld_data,
	output svt_pkg::entry_t q
);
	import svt_pkg::*;

	entry_t entry_q;

	// load wins over shift: the tail cell takes the popped head while the row advances
	always_ff @(posedge clk) begin
		if (load) begin
			entry_q <= ld_data;
		end else if (shift) begin
			entry_q <= nbr;
		end
	end

	assign q = entry_q;

endmodule

`default_nettype wire

### hw/rtl/satellite_view_table.sv
// Top level of the satellite view table: two cell chains and the operation sequencer.
//
// Each input beat carries one operation (purge a system, add a view entry, add a used
// entry, clear the used set, clear both tables, query) and yields exactly one result
// beat with the per-system counts, the totals, the match flag and the accepted flag.
// Both tables are rows of cells that rotate like queues through a head cell: every
// operation walks the used set once to count and match, applies the used-set change,
// then, unless it clears both tables, walks the view table once to count and, for a
// purge, drop entries while the survivors keep their order. The next input beat is
// taken only in idle, once the result of the last item has been registered. A result
// waits in the output register while the next input beat is taken, and the sequencer
// holds only if a second result is ready before the first has been taken.
`default_nettype none

module satellite_view_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [2:0] sat_system, [10:3] sat_number, [15:11] zero
	input  logic [svt_pkg::S_TDATA_W-1:0] s_tdata,
	// [2:0] mode
	input  logic [svt_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [5:0] view_of_system, [10:6] use_of_system, [16:11] view_total,
	// [21:17] use_total, [22] match_flag, [23] accepted
	output logic [svt_pkg::M_TDATA_W-1:0] m_tdata
);
	import svt_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_UWALK = 3'd1;
	localparam logic [2:0] ST_UPD   = 3'd2;
	localparam logic [2:0] ST_VWALK = 3'd3;
	localparam logic [2:0] ST_VADD  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]         state_q;
	logic [MODE_W-1:0]  mode_q;
	logic [SYS_W-1:0]   sys_q;
	logic [NUM_W-1:0]   num_q;
	logic [CNT_W-1:0]   rem_q;      // entries left in the current walk
	logic [VIEW_FW-1:0] vfill_q;
	logic [USE_FW-1:0]  ufill_q;
	logic [VIEW_FW-1:0] vcnt_q;
	logic [USE_FW-1:0]  ucnt_q;
	logic               match_q;
	logic               acc_q;
	logic               m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	// Cell rows
	entry_t             v_q [VIEW_DEPTH];
	entry_t             u_q [USE_DEPTH];
	logic [VIEW_DEPTH-1:0] v_ld;
	logic [USE_DEPTH-1:0]  u_ld;

	entry_t             u_head, v_head;
	entry_t             u_ld_data, v_ld_data;
	logic               u_hit, u_same, v_same, v_drop;
	logic               u_step, v_step, u_add, v_add;
	logic               u_shift, v_shift, u_ld_en, v_ld_en;
	logic [USE_FW-1:0]  ufill_m1;
	logic [VIEW_FW-1:0] vfill_m1;
	logic [USE_IW-1:0]  u_ld_idx;
	logic [VIEW_IW-1:0] v_ld_idx;
	logic               in_beat;

	assign in_beat = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);

	// Head cells: the entry under inspection in each walk
	assign u_head = u_q[0];
	assign v_head = v_q[0];

	// Used-set match treats an unknown system on either side as a wildcard
	assign u_hit  = (u_head.num == num_q) &&
	                ((u_head.sys == sys_q) || (u_head.sys == SYS_UNKNOWN) ||
	                 (sys_q == SYS_UNKNOWN));
	assign u_same = (u_head.sys == sys_q);
	assign v_same = (v_head.sys == sys_q);
	assign v_drop = (mode_q == MODE_PURGE) && v_same;

	assign u_step = (state_q == ST_UWALK) && (rem_q != '0);
	assign v_step = (state_q == ST_VWALK) && (rem_q != '0);

	// Store a new used entry: non-zero id, room left, no match already
	assign u_add = (state_q == ST_UPD) && (mode_q == MODE_ADD_USE) && (num_q != '0) &&
	               (ufill_q < USE_FW'(USE_DEPTH)) && !match_q;
	assign v_add = (state_q == ST_VADD) && (mode_q == MODE_ADD_VIEW) &&
	               (vfill_q < VIEW_FW'(VIEW_DEPTH));

	// A walk step pops the head and, unless dropped, reloads it at the queue tail
	assign ufill_m1 = ufill_q - USE_FW'(1);
	assign vfill_m1 = vfill_q - VIEW_FW'(1);

	assign u_shift  = u_step;
	assign u_ld_en  = u_step || u_add;
	assign u_ld_idx = u_step ? ufill_m1[USE_IW-1:0] : ufill_q[USE_IW-1:0];
	assign u_ld_data = u_step ? u_head : entry_t'{sys: sys_q, num: num_q, mark: 1'b0};

	assign v_shift  = v_step;
	assign v_ld_en  = (v_step && !v_drop) || v_add;
	assign v_ld_idx = v_step ? vfill_m1[VIEW_IW-1:0] : vfill_q[VIEW_IW-1:0];
	assign v_ld_data = v_step ? v_head : entry_t'{sys: sys_q, num: num_q, mark: match_q};

	genvar gi;
	for (gi = 0; gi < VIEW_DEPTH; gi++) begin : g_view
		assign v_ld[gi] = v_ld_en && (v_ld_idx == VIEW_IW'(gi));
		svt_cell u_cell (
			.clk     (clk),
			.shift   (v_shift),
			.load    (v_ld[gi]),
			.nbr     (v_q[(gi + 1) % VIEW_DEPTH]),
			.ld_data (v_ld_data),
			.q       (v_q[gi])
		);
	end

	for (gi = 0; gi < USE_DEPTH; gi++) begin : g_use
		assign u_ld[gi] = u_ld_en && (u_ld_idx == USE_IW'(gi));
		svt_cell u_cell (
			.clk     (clk),
			.shift   (u_shift),
			.load    (u_ld[gi]),
			.nbr     (u_q[(gi + 1) % USE_DEPTH]),
			.ld_data (u_ld_data),
			.q       (u_q[gi])
		);
	end

	// Sequencer: used walk, used update, view walk, view append, result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mode_q     <= '0;
			sys_q      <= '0;
			num_q      <= '0;
			rem_q      <= '0;
			vfill_q    <= '0;
			ufill_q    <= '0;
			vcnt_q     <= '0;
			ucnt_q     <= '0;
			match_q    <= 1'b0;
			acc_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			// drop the result once taken, unless the next one replaces it this cycle
			if (m_tvalid_q && m_tready && (state_q != ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						mode_q  <= s_tuser;
						sys_q   <= s_tdata[SYS_W-1:0];
						num_q   <= s_tdata[SYS_W+NUM_W-1:SYS_W];
						rem_q   <= CNT_W'(ufill_q);
						vcnt_q  <= '0;
						ucnt_q  <= '0;
						match_q <= 1'b0;
						acc_q   <= 1'b0;
						state_q <= ST_UWALK;
					end
				end
				ST_UWALK: begin
					if (rem_q != '0) begin
						rem_q <= rem_q - CNT_W'(1);
						if (u_hit) begin
							match_q <= 1'b1;
						end
						if (u_same) begin
							ucnt_q <= ucnt_q + USE_FW'(1);
						end
					end else begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					case (mode_q)
						MODE_CLR_USE: begin
							ufill_q <= '0;
							ucnt_q  <= '0;
							match_q <= 1'b0;
						end
						MODE_CLR_ALL: begin
							ufill_q <= '0;
							vfill_q <= '0;
							ucnt_q  <= '0;
							match_q <= 1'b0;
						end
						MODE_ADD_USE: begin
							if (u_add) begin
								ufill_q <= ufill_q + USE_FW'(1);
								ucnt_q  <= ucnt_q + USE_FW'(1);
								match_q <= 1'b1;
								acc_q   <= 1'b1;
							end
						end
						default: begin
						end
					endcase
					rem_q   <= (mode_q == MODE_CLR_ALL) ? '0 : CNT_W'(vfill_q);
					state_q <= ST_VWALK;
				end
				ST_VWALK: begin
					if (rem_q != '0) begin
						rem_q <= rem_q - CNT_W'(1);
						if (v_drop) begin
							vfill_q <= vfill_m1;
						end else if (v_same) begin
							vcnt_q <= vcnt_q + VIEW_FW'(1);
						end
					end else begin
						state_q <= ST_VADD;
					end
				end
				ST_VADD: begin
					if (v_add) begin
						vfill_q <= vfill_q + VIEW_FW'(1);
						vcnt_q  <= vcnt_q + VIEW_FW'(1);
						acc_q   <= 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// hold until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q  <= {acc_q, match_q, UT_W'(ufill_q), VT_W'(vfill_q),
						               UOS_W'(ucnt_q), VOS_W'(vcnt_q)};
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
	a_vfill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vfill_q <= VIEW_FW'(VIEW_DEPTH))
		else $error("view fill beyond table depth");

	a_ufill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ufill_q <= USE_FW'(USE_DEPTH))
		else $error("used fill beyond set depth");

	a_walk_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> rem_q == '0)
		else $error("walk counter left non-zero");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !$rose(m_tvalid_q))
		else $error("result raised straight after an input beat");
`endif

endmodule

`default_nettype wire

### tb/sat_table_checker.sv
// Watches both stream channels, mirrors the two satellite tables and checks every result beat.
`default_nettype none

module sat_table_checker
	import svt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic [S_TUSER_W-1:0] s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,
	output int                   pending,
	output int                   fail_count,
	output int                   checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [VOS_W-1:0] view_of_sys;
		logic [UOS_W-1:0] use_of_sys;
		logic [VT_W-1:0]  view_total;
		logic [UT_W-1:0]  use_total;
		logic             match;
		logic             accepted;
	} sat_counts_t;

	// Mirror of the view table and the used set
	logic [SYS_W-1:0] vis_sys  [VIEW_DEPTH];
	logic [NUM_W-1:0] vis_id   [VIEW_DEPTH];
	logic             vis_mark [VIEW_DEPTH];
	int               vis_fill;
	logic [SYS_W-1:0] fix_sys  [USE_DEPTH];
	logic [NUM_W-1:0] fix_id   [USE_DEPTH];
	int               fix_fill;

	sat_counts_t counts_due[$];
	sat_counts_t due;
	int          mismatches;
	int          results_seen;

	// Unknown on either side matches any system
	function automatic bit fix_holds(logic [SYS_W-1:0] sys, logic [NUM_W-1:0] id);
		for (int k = 0; k < fix_fill; k++) begin
			if (fix_id[k] == id &&
			    (fix_sys[k] == sys || fix_sys[k] == SYS_UNKNOWN || sys == SYS_UNKNOWN))
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic sat_counts_t apply_sat_op(logic [MODE_W-1:0] op, logic [SYS_W-1:0] sys,
	                                             logic [NUM_W-1:0] id);
		sat_counts_t r;
		int kept;
		int v_cnt;
		int u_cnt;
		r.accepted = 1'b0;
		case (op)
			MODE_PURGE: begin
				// compact in place, survivors keep their order
				kept = 0;
				for (int k = 0; k < vis_fill; k++) begin
					if (vis_sys[k] != sys) begin
						vis_sys[kept]  = vis_sys[k];
						vis_id[kept]   = vis_id[k];
						vis_mark[kept] = vis_mark[k];
						kept++;
					end
				end
				vis_fill = kept;
			end
			MODE_ADD_VIEW: begin
				if (vis_fill < VIEW_DEPTH) begin
					vis_sys[vis_fill]  = sys;
					vis_id[vis_fill]   = id;
					vis_mark[vis_fill] = fix_holds(sys, id);
					vis_fill++;
					r.accepted = 1'b1;
				end
			end
			MODE_ADD_USE: begin
				if (id != '0 && fix_fill < USE_DEPTH && !fix_holds(sys, id)) begin
					fix_sys[fix_fill] = sys;
					fix_id[fix_fill]  = id;
					fix_fill++;
					r.accepted = 1'b1;
				end
			end
			MODE_CLR_USE: begin
				fix_fill = 0;
			end
			MODE_CLR_ALL: begin
				vis_fill = 0;
				fix_fill = 0;
			end
			default: begin
			end
		endcase
		// counts use an exact system compare
		v_cnt = 0;
		u_cnt = 0;
		for (int k = 0; k < vis_fill; k++)
			if (vis_sys[k] == sys) v_cnt++;
		for (int k = 0; k < fix_fill; k++)
			if (fix_sys[k] == sys) u_cnt++;
		r.view_of_sys = VOS_W'(v_cnt);
		r.use_of_sys  = UOS_W'(u_cnt);
		r.view_total  = VT_W'(vis_fill);
		r.use_total   = UT_W'(fix_fill);
		r.match       = fix_holds(sys, id);
		return r;
	endfunction

	task automatic check_field(string field, logic [7:0] want, logic [7:0] seen);
		if (want !== seen) begin
			$error("%s: expected %0d, got %0d", field, want, seen);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vis_fill = 0;
			fix_fill = 0;
			counts_due.delete();
			mismatches = 0;
			results_seen = 0;
			pending <= 0;
			fail_count <= 0;
			checked <= 0;
		end else begin
			// take the operation first so a same-edge result still finds its entry
			if (s_tvalid && s_tready)
				counts_due.push_back(apply_sat_op(s_tuser, s_tdata[SYS_W-1:0],
				                                  s_tdata[SYS_W+NUM_W-1:SYS_W]));
			if (m_tvalid && m_tready) begin
				if (counts_due.size() == 0) begin
					$error("result beat %h with no operation outstanding", m_tdata);
					mismatches++;
				end else begin
					due = counts_due.pop_front();
					check_field("view_of_system", 8'(due.view_of_sys), 8'(m_tdata[5:0]));
					check_field("use_of_system", 8'(due.use_of_sys), 8'(m_tdata[10:6]));
					check_field("view_total", 8'(due.view_total), 8'(m_tdata[16:11]));
					check_field("use_total", 8'(due.use_total), 8'(m_tdata[21:17]));
					check_field("match_flag", 8'(due.match), 8'(m_tdata[22]));
					check_field("accepted", 8'(due.accepted), 8'(m_tdata[23]));
					results_seen++;
				end
			end
			pending <= counts_due.size();
			fail_count <= mismatches;
			checked <= results_seen;
		end
	end

endmodule

`default_nettype wire

### tb/tb.sv
// Testbench top for the satellite view table: clock, reset, operation stimulus and verdict.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import svt_pkg::*;

	// Operation codes the package leaves unnamed: query, and two spare codes that act as one
	localparam logic [MODE_W-1:0] MODE_QUERY   = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

	localparam logic [SYS_W-1:0] SYS_GPS     = 3'd0;
	localparam logic [SYS_W-1:0] SYS_GLONASS = 3'd1;
	localparam logic [SYS_W-1:0] SYS_BEIDOU  = 3'd2;
	localparam logic [SYS_W-1:0] SYS_QZSS    = 3'd3;
	localparam logic [SYS_W-1:0] SYS_ODD     = 3'd7;

	// Kinds of random run
	localparam int STYLE_FILL  = 0;
	localparam int STYLE_MIXED = 1;
	localparam int STYLE_NOISE = 2;

	localparam int N_ITEMS     = 750;
	localparam int HOLD_CYCLES = 300;
	// quiet stretches come from items in the block plus idling; the hold-off dominates
	localparam int QUIET_LIMIT = 4000;
	localparam int TAIL_CYCLES = 80;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic [S_TUSER_W-1:0] s_tuser  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	int pending;
	int fail_count;
	int checked;

	int send_idle_pct = 0;
	int stall_pct     = 0;
	bit hold_go       = 1'b0;
	bit hold_seen;
	int hold_left;
	int items_sent    = 0;
	int quiet_cycles  = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	satellite_view_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	sat_table_checker audit (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.pending    (pending),
		.fail_count (fail_count),
		.checked    (checked)
	);

	// Result side: random stalls, plus one long hold-off triggered by a toggle of hold_go.
	// The hold-off is counted here so the sender keeps offering beats meanwhile.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_seen <= 1'b0;
			hold_left <= 0;
		end else if (hold_go != hold_seen) begin
			hold_seen <= hold_go;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Watchdog: end the run if no beat moves on either side for too long
	always @(posedge clk) begin
		if (arst_n && !((s_tvalid && s_tready) || (m_tvalid && m_tready))) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Watchdog: no beat accepted for %0d cycles, %0d results outstanding",
				         quiet_cycles, pending);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end else begin
			quiet_cycles <= 0;
		end
	end

	// Offer one operation beat, after a random idle gap, and hold it until taken.
	// Called just after an edge, so s_tvalid gets one assignment per step.
	task automatic send_beat(input logic [MODE_W-1:0] op, input logic [SYS_W-1:0] sys,
	                         input logic [NUM_W-1:0] id);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {{(S_TDATA_W - NUM_W - SYS_W){1'b0}}, id, sys};
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// Drop valid and wait for every outstanding result to come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic pick_op(input int style, output logic [MODE_W-1:0] op,
	                       output logic [SYS_W-1:0] sys, output logic [NUM_W-1:0] id);
		int roll;
		roll = $urandom_range(0, 99);
		case (style)
			STYLE_FILL: begin
				if (roll < 55) op = MODE_ADD_VIEW;
				else if (roll < 95) op = MODE_ADD_USE;
				else op = MODE_QUERY;
			end
			STYLE_MIXED: begin
				if (roll < 34) op = MODE_ADD_VIEW;
				else if (roll < 58) op = MODE_ADD_USE;
				else if (roll < 70) op = MODE_PURGE;
				else if (roll < 82) op = MODE_QUERY;
				else if (roll < 88) op = MODE_CLR_USE;
				else if (roll < 92) op = MODE_CLR_ALL;
				else if (roll < 96) op = MODE_SPARE_A;
				else op = MODE_SPARE_B;
			end
			default: begin
				op = MODE_W'($urandom_range(0, 7));
			end
		endcase
		// keep mostly to real constellations so counts and matches stay busy
		roll = $urandom_range(0, 99);
		if (style == STYLE_NOISE || roll >= 90)
			sys = SYS_W'($urandom_range(0, 7));
		else
			sys = SYS_W'($urandom_range(0, 4));
		// a narrow id range provokes duplicates and wildcard hits
		roll = $urandom_range(0, 99);
		if (roll < 60) id = NUM_W'($urandom_range(1, 12));
		else if (roll < 90) id = NUM_W'($urandom_range(0, 255));
		else if (roll < 95) id = '0;
		else id = '1;
	endtask

	initial begin
		logic [MODE_W-1:0] op;
		logic [SYS_W-1:0]  sys;
		logic [NUM_W-1:0]  id;
		int                style;
		int                run_len;
		int                phase;
		int                next_phase;
		bit                held;

		phase = 0;
		held = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty tables, id zero, duplicates, wildcard on both sides,
		// codes above unknown, exact-compare purge, spare modes, both clears
		send_beat(MODE_QUERY, SYS_GPS, '0);
		send_beat(MODE_ADD_USE, SYS_GPS, '0);
		send_beat(MODE_ADD_USE, SYS_GPS, '1);
		send_beat(MODE_ADD_USE, SYS_GPS, '1);
		send_beat(MODE_ADD_USE, SYS_UNKNOWN, '1);
		send_beat(MODE_ADD_USE, SYS_UNKNOWN, 8'd7);
		send_beat(MODE_ADD_VIEW, SYS_GLONASS, 8'd7);
		send_beat(MODE_ADD_VIEW, SYS_GPS, '0);
		send_beat(MODE_ADD_VIEW, SYS_ODD, '1);
		send_beat(MODE_ADD_USE, SYS_ODD, '1);
		send_beat(MODE_ADD_VIEW, SYS_UNKNOWN, '1);
		send_beat(MODE_ADD_VIEW, SYS_QZSS, 8'd128);
		send_beat(MODE_PURGE, SYS_UNKNOWN, '1);
		send_beat(MODE_SPARE_A, SYS_ODD, '1);
		send_beat(MODE_SPARE_B, SYS_BEIDOU, 8'd7);
		send_beat(MODE_PURGE, SYS_GLONASS, 8'd7);
		send_beat(MODE_CLR_USE, SYS_GPS, '1);
		send_beat(MODE_QUERY, SYS_UNKNOWN, 8'd7);
		send_beat(MODE_CLR_ALL, SYS_QZSS, 8'd128);

		// Random runs; the idling pattern moves on each quarter, with a drain in between
		while (items_sent < N_ITEMS) begin
			next_phase = items_sent * 4 / N_ITEMS;
			if (next_phase != phase) begin
				drain_results();
				phase = next_phase;
				case (phase)
					1: begin
						send_idle_pct = 82;
						stall_pct <= 0;
					end
					2: begin
						send_idle_pct = 0;
						stall_pct <= 82;
					end
					default: begin
						send_idle_pct = 12;
						stall_pct <= 12;
					end
				endcase
			end
			// one long back-pressure stretch while the sender keeps offering
			if (!held) begin
				hold_go <= ~hold_go;
				held = 1'b1;
			end
			style = $urandom_range(0, 99);
			if (style < 40) begin
				style = STYLE_FILL;
				run_len = $urandom_range(50, 80);
				send_beat(MODE_CLR_ALL, SYS_W'($urandom_range(0, 7)), NUM_W'($urandom));
			end else if (style < 85) begin
				style = STYLE_MIXED;
				run_len = $urandom_range(20, 70);
			end else begin
				style = STYLE_NOISE;
				run_len = $urandom_range(20, 40);
			end
			repeat (run_len) begin
				pick_op(style, op, sys, id);
				send_beat(op, sys, id);
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Summary: %0d operations sent, %0d result beats checked field by field",
		         items_sent, checked);
		$display("Summary: directed edge cases, table-filling, mixed and noise runs; %0s",
		         "free flow, sender idling, receiver stalls, both, one long hold-off");
		if (fail_count == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
hw/rtl/svt_pkg.sv
hw/rtl/svt_cell.sv
hw/rtl/satellite_view_table.sv
tb/sat_table_checker.sv
tb/tb.sv
